// ----- sv/shamh_pkg.sv -----
// shared types, constants and helper functions of the sha-256 message hasher
// no dependencies; imported by shamh_round, shamh_out_buf and sha256_message_hasher
package shamh_pkg;

	typedef logic [31:0] word32_t;
	typedef logic [7:0][31:0] hash_t;
	typedef logic [15:0][31:0] block_t;

	localparam logic [5:0] FILL_MAX = 6'd63;
	localparam logic [5:0] PAD_SPLIT = 6'd56;
	localparam logic [5:0] RND_LAST = 6'd63;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [3:0] DIGEST_WORDS = 4'd8;

	localparam hash_t SHA_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word32_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// place one message byte into its lane, first byte most significant
	function automatic word32_t put_byte(word32_t w, logic [1:0] lane, logic [7:0] b);
		word32_t r;
		r = w;
		unique case (lane)
			2'd0: r[31:24] = b;
			2'd1: r[23:16] = b;
			2'd2: r[15:8] = b;
			2'd3: r[7:0] = b;
			default: r = w;
		endcase
		return r;
	endfunction

	// padding marker at the fill position, zeros after it
	function automatic word32_t pad_word(word32_t w, logic [3:0] widx, logic [5:0] fill);
		word32_t r;
		logic [5:0] pos;
		int j;
		r = w;
		for (j = 0; j < 4; j++) begin
			pos = {widx, 2'(j)};
			if (pos == fill) begin
				r[8 * (3 - j) +: 8] = PAD_BYTE;
			end else if (pos > fill) begin
				r[8 * (3 - j) +: 8] = 8'h00;
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/shamh_round.sv -----
// one sha-256 round and one message schedule expansion step
// depends on shamh_pkg
module shamh_round (
	input  shamh_pkg::hash_t   vars,
	input  shamh_pkg::block_t  win,
	input  shamh_pkg::word32_t k,
	output shamh_pkg::hash_t   vars_next,
	output shamh_pkg::word32_t w_next
);
	import shamh_pkg::*;

	function automatic word32_t rotr(word32_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	word32_t a, b, c, d, e, f, g, h;
	word32_t big_s0, big_s1, ch, maj, t1, t2;
	word32_t sm_s0, sm_s1;

	always_comb begin
		a = vars[0];
		b = vars[1];
		c = vars[2];
		d = vars[3];
		e = vars[4];
		f = vars[5];
		g = vars[6];
		h = vars[7];
		big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
		big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
		ch = (e & f) ^ (~e & g);
		maj = (a & b) ^ (a & c) ^ (b & c);
		t1 = h + big_s1 + ch + k + win[0];
		t2 = big_s0 + maj;
		vars_next[0] = t1 + t2;
		vars_next[1] = a;
		vars_next[2] = b;
		vars_next[3] = c;
		vars_next[4] = d + t1;
		vars_next[5] = e;
		vars_next[6] = f;
		vars_next[7] = g;
	end

	// word sixteen places ahead of the one used in this round
	always_comb begin
		sm_s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
		sm_s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
		w_next = sm_s1 + win[9] + sm_s0 + win[0];
	end

endmodule

// ----- sv/shamh_out_buf.sv -----
// digest output buffer: holds eight words and hands them out one per transfer
// depends on shamh_pkg
module shamh_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  shamh_pkg::hash_t   digest,
	output logic               busy,
	output logic               dig_valid,
	input  logic               dig_stall,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               last_word
);
	import shamh_pkg::*;

	hash_t      buf_q;
	logic [3:0] cnt_q;
	logic [2:0] idx_q;
	logic       xfer;

	assign dig_valid = (cnt_q != 4'd0);
	assign busy = dig_valid;
	assign xfer = dig_valid && !dig_stall;
	assign digest_word = buf_q[0];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
			idx_q <= 3'd0;
		end else if (load) begin
			cnt_q <= DIGEST_WORDS;
			idx_q <= 3'd0;
		end else if (xfer) begin
			cnt_q <= cnt_q - 4'd1;
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= digest;
		end else if (xfer) begin
			buf_q <= {32'h0, buf_q[7:1]};
		end
	end

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 4'd0))
		else $error("digest loaded over pending words");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && last_word) |=> !dig_valid)
		else $error("words pending after last transfer");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (({1'b0, idx_q} + cnt_q) == DIGEST_WORDS))
		else $error("word index and count out of step");

endmodule

// ----- sv/sha256_message_hasher.sv -----
// sha-256 message hasher top level: byte intake, sequencer and chaining state
// depends on shamh_pkg, shamh_round and shamh_out_buf
//
// usage
// - msg channel (msg_valid, msg_stall): one transfer per message byte; byte_present
//   marks a real byte, last_item ends the message (with or without a byte)
// - dig channel (dig_valid, dig_stall): eight transfers per message, digest_word
//   most significant word first, word_index 0..7, last_word on word 7
// - a byte is taken every cycle while a 64-byte block fills; the 64th byte starts
//   the compression, one round per cycle on the shared round unit: 64 rounds
//   followed by one add step
// - end of message: a pad step and one compression, or a pad step, a compression, a
//   length step and a second compression when fewer than 9 bytes of room remain; then
//   the digest moves into the output buffer and the first word is shown the next cycle
// - msg_stall is high from the 64th byte or the end of message until the
//   compression is done
// - reset loads the initial hash values, clears length and fill, drops dig_valid
// - a stalled dig channel holds its word; the next message is taken meanwhile and
//   only its final add waits until the buffer has drained
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last_item,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shamh_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_LEN   = 5'b00100,
		ST_ROUND = 5'b01000,
		ST_ADD   = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		PASS_DATA  = 2'd0,
		PASS_PAD   = 2'd1,
		PASS_FINAL = 2'd2
	} pass_t;

	state_t      state_q;
	pass_t       pass_q;
	logic        last_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [60:0] bytes_q;
	hash_t       chain_q;
	hash_t       vars_q;
	block_t      win_q;
	block_t      win_d;
	hash_t       vars_next;
	hash_t       chain_sum;
	word32_t     w_next;
	logic [63:0] bit_len;
	logic        msg_xfer;
	logic        block_full;
	logic        pad_two;
	logic        load_vars;
	logic        out_load;
	logic        out_busy;

	assign msg_stall = (state_q != ST_IDLE);
	assign msg_xfer = msg_valid && !msg_stall;
	assign block_full = msg_xfer && byte_present && (fill_q == FILL_MAX);
	assign pad_two = (fill_q >= PAD_SPLIT);
	assign bit_len = {bytes_q, 3'b000};
	assign load_vars = block_full || (state_q == ST_PAD) || (state_q == ST_LEN);
	assign out_load = (state_q == ST_ADD) && (pass_q == PASS_FINAL) && !out_busy;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chain_sum[i] = chain_q[i] + vars_q[i];
		end
	end

	shamh_round u_round (
		.vars      (vars_q),
		.win       (win_q),
		.k         (ROUND_K[rnd_q]),
		.vars_next (vars_next),
		.w_next    (w_next)
	);

	shamh_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (out_load),
		.digest      (chain_sum),
		.busy        (out_busy),
		.dig_valid   (dig_valid),
		.dig_stall   (dig_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// message block and schedule window share one 16-word shift line
	always_comb begin
		win_d = win_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_xfer && byte_present) begin
					win_d[fill_q[5:2]] = put_byte(win_q[fill_q[5:2]], fill_q[1:0], data_byte);
				end
			end
			ST_PAD: begin
				for (int i = 0; i < 16; i++) begin
					win_d[i] = pad_word(win_q[i], 4'(i), fill_q);
				end
				if (!pad_two) begin
					win_d[14] = bit_len[63:32];
					win_d[15] = bit_len[31:0];
				end
			end
			ST_LEN: begin
				win_d = '0;
				win_d[14] = bit_len[63:32];
				win_d[15] = bit_len[31:0];
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++) begin
					win_d[i] = win_q[i + 1];
				end
				win_d[15] = w_next;
			end
			ST_ADD: win_d = win_q;
			default: win_d = win_q;
		endcase
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
		if (load_vars) begin
			vars_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			vars_q <= vars_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= PASS_DATA;
			last_q <= 1'b0;
			fill_q <= 6'd0;
			rnd_q <= 6'd0;
			bytes_q <= 61'd0;
			chain_q <= SHA_IV;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (msg_xfer) begin
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							bytes_q <= bytes_q + 61'd1;
						end
						if (block_full) begin
							pass_q <= PASS_DATA;
							last_q <= last_item;
							rnd_q <= 6'd0;
							state_q <= ST_ROUND;
						end else if (last_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pass_q <= pad_two ? PASS_PAD : PASS_FINAL;
					rnd_q <= 6'd0;
					state_q <= ST_ROUND;
				end
				ST_LEN: begin
					pass_q <= PASS_FINAL;
					rnd_q <= 6'd0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					unique case (pass_q)
						PASS_DATA: begin
							chain_q <= chain_sum;
							state_q <= last_q ? ST_PAD : ST_IDLE;
						end
						PASS_PAD: begin
							chain_q <= chain_sum;
							state_q <= ST_LEN;
						end
						PASS_FINAL: begin
							if (!out_busy) begin
								chain_q <= SHA_IV;
								fill_q <= 6'd0;
								bytes_q <= 61'd0;
								state_q <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_full_starts: assert property (@(posedge clk) disable iff (!arst_n)
		block_full |=> (state_q == ST_ROUND))
		else $error("full block did not start compression");

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == RND_LAST) |=> (state_q == ST_ADD))
		else $error("round sequence did not end in add");

	a_add_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (rnd_q == 6'd0))
		else $error("add reached before 64 rounds");

endmodule
